// ===== hw/rtl/rpap_pkg.sv =====
package rpap_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COORD_WIDTH_DEF  = 32;

  // CORDIC datapath width, angle and rotation values in Q4.30
  localparam int CORDIC_W  = 34;
  localparam int FRAC_BITS = 30;
  localparam int ATAN_ENTRIES = 30;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(32'd652032874);

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BL = 2'd2,
    CORNER_BR = 2'd3
  } corner_t;

  typedef enum logic {
    KIND_POINT = 1'b0,
    KIND_RECT  = 1'b1
  } kind_t;

  function automatic logic [CORDIC_W-1:0] atan_at(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000008;
      28: v = 32'h00000004;
      29: v = 32'h00000002;
      default: v = 32'h00000000;
    endcase
    return {{(CORDIC_W-32){1'b0}}, v};
  endfunction

endpackage

// ===== hw/rtl/rpap_cordic_cell.sv =====
module rpap_cordic_cell import rpap_pkg::*; #(
  parameter int SHIFT  = 0,
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       v_in,
  input  logic signed [CORDIC_W-1:0] x_in,
  input  logic signed [CORDIC_W-1:0] y_in,
  input  logic signed [CORDIC_W-1:0] z_in,
  input  logic        [SIDE_W-1:0]   side_in,
  output logic                       v_out,
  output logic signed [CORDIC_W-1:0] x_out,
  output logic signed [CORDIC_W-1:0] y_out,
  output logic signed [CORDIC_W-1:0] z_out,
  output logic        [SIDE_W-1:0]   side_out
);

  localparam logic signed [CORDIC_W-1:0] ATAN = atan_at(SHIFT);

  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  logic signed [CORDIC_W-1:0] x_next;
  logic signed [CORDIC_W-1:0] y_next;
  logic signed [CORDIC_W-1:0] z_next;

  always_comb begin
    xs = x_in >>> SHIFT;
    ys = y_in >>> SHIFT;
    if (!z_in[CORDIC_W-1]) begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - ATAN;
    end else begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= x_next;
      y_out    <= y_next;
      z_out    <= z_next;
      side_out <= side_in;
    end
  end

endmodule

// ===== hw/rtl/rpap_mixer.sv =====
module rpap_mixer import rpap_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH:0]   u,
  input  logic signed [COORD_WIDTH:0]   v,
  input  logic signed [CORDIC_W-1:0]    cu,
  input  logic signed [CORDIC_W-1:0]    cv,
  input  logic signed [COORD_WIDTH-1:0] c,
  output logic signed [COORD_WIDTH-1:0] res
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int DL = DW / 2;
  localparam int DH = DW - DL;
  localparam int LW = DL + 1 + CORDIC_W;
  localparam int HW = DH + CORDIC_W;
  localparam int PW = DW + CORDIC_W;
  localparam int SW = PW + 1;
  localparam int QW = SW - FRAC_BITS;
  localparam int RW = QW + 1;
  localparam logic [SW-1:0] ROUND_C = SW'(1) << (FRAC_BITS - 1);

  logic signed [LW-1:0] pu_lo, pv_lo;
  logic signed [HW-1:0] pu_hi, pv_hi;
  logic signed [PW-1:0] pu, pv;
  logic signed [QW-1:0] q;
  logic signed [CW-1:0] c1, c2, c3;

  logic signed [DL:0]   ul_s, vl_s;
  logic signed [DH-1:0] uh_s, vh_s;
  logic signed [PW-1:0] pu_next, pv_next;
  logic        [SW-1:0] s_next;
  logic signed [RW-1:0] r_next;
  logic signed [CW-1:0] res_next;

  always_comb begin
    ul_s = $signed({1'b0, u[DL-1:0]});
    vl_s = $signed({1'b0, v[DL-1:0]});
    uh_s = u[DW-1:DL];
    vh_s = v[DW-1:DL];
    pu_next = {pu_hi, {DL{1'b0}}} + {{(PW-LW){pu_lo[LW-1]}}, pu_lo};
    pv_next = {pv_hi, {DL{1'b0}}} + {{(PW-LW){pv_lo[LW-1]}}, pv_lo};
    s_next = {pu[PW-1], pu} + {pv[PW-1], pv} + ROUND_C;
    r_next = {q[QW-1], q} + {{(RW-CW){c3[CW-1]}}, c3};
    if ((&r_next[RW-1:CW-1]) || !(|r_next[RW-1:CW-1])) begin
      res_next = r_next[CW-1:0];
    end else if (r_next[RW-1]) begin
      res_next = {1'b1, {(CW-1){1'b0}}};
    end else begin
      res_next = {1'b0, {(CW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pu_lo <= ul_s * cu;
      pv_lo <= vl_s * cv;
      pu_hi <= uh_s * cu;
      pv_hi <= vh_s * cv;
      c1    <= c;
      pu    <= pu_next;
      pv    <= pv_next;
      c2    <= c1;
      q     <= s_next[SW-1:FRAC_BITS];
      c3    <= c2;
      res   <= res_next;
    end
  end

endmodule

// ===== hw/rtl/rotate_point_about_pivot.sv =====
// Throughput: one result per cycle while out_ready does not stall the output;
// a point gives one result and a rectangle four, set by the single corner issue
// port feeding one CORDIC cell chain and one mixer pair.
// Reset: synchronous, active high; clears the corner counter and all valid flags.
module rotate_point_about_pivot import rpap_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] pivot_x,
  input  logic signed [COORD_WIDTH-1:0] pivot_y,
  input  logic        [15:0]            angle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic        [1:0]             corner,
  output logic                          last
);

  localparam int CW     = COORD_WIDTH;
  localparam int DW     = CW + 1;
  localparam int SIDE_W = 5 + 2 * DW + 2 * CW;
  localparam int MIX_LAT = 4;
  localparam logic [32:0] ZSCALE = 33'd6746518852;

  logic    adv;
  corner_t cnt;
  logic    cnt_last;

  logic signed [CW-1:0] px_sel, py_sel;
  logic signed [DW-1:0] dx_next, dy_next;
  logic        [46:0]   zp;

  logic                       v_s0;
  logic signed [CORDIC_W-1:0] z_s0;
  logic        [SIDE_W-1:0]   side_s0;

  logic                       v_c    [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] x_c    [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] y_c    [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] z_c    [0:CORDIC_STEPS];
  logic        [SIDE_W-1:0]   side_c [0:CORDIC_STEPS];

  logic signed [CORDIC_W-1:0] xe, ye;
  logic        [SIDE_W-1:0]   side_e;
  quad_t                      quad_e;
  logic signed [CORDIC_W-1:0] cs_next, sn_next;

  logic                       v_map;
  logic signed [CORDIC_W-1:0] cs, sn, sn_neg;
  logic signed [DW-1:0]       dx, dy;
  logic signed [CW-1:0]       cx, cy;
  logic        [1:0]          corner_map;
  logic                       last_map;

  logic       v_m      [0:MIX_LAT-1];
  logic [1:0] corner_m [0:MIX_LAT-1];
  logic       last_m   [0:MIX_LAT-1];

  assign adv      = !out_valid || out_ready;
  assign cnt_last = (kind == KIND_POINT) || (cnt == CORNER_BR);
  assign in_ready = adv && cnt_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= CORNER_TL;
    end else if (adv && in_valid && (kind == KIND_RECT)) begin
      cnt <= corner_t'(cnt + 2'd1);
    end
  end

  always_comb begin
    px_sel  = cnt[0] ? second_x : first_x;
    py_sel  = cnt[1] ? second_y : first_y;
    dx_next = {px_sel[CW-1], px_sel} - {pivot_x[CW-1], pivot_x};
    dy_next = {py_sel[CW-1], py_sel} - {pivot_y[CW-1], pivot_y};
    zp      = angle[13:0] * ZSCALE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s0 <= 1'b0;
    end else if (adv) begin
      v_s0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z_s0    <= $signed({{(CORDIC_W-31){1'b0}}, zp[46:16]});
      side_s0 <= {angle[15:14], (kind == KIND_RECT) ? cnt : CORNER_TL, cnt_last,
                  dx_next, dy_next, pivot_x, pivot_y};
    end
  end

  assign v_c[0]    = v_s0;
  assign x_c[0]    = CORDIC_GAIN;
  assign y_c[0]    = '0;
  assign z_c[0]    = z_s0;
  assign side_c[0] = side_s0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    rpap_cordic_cell #(
      .SHIFT  (i),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .v_in     (v_c[i]),
      .x_in     (x_c[i]),
      .y_in     (y_c[i]),
      .z_in     (z_c[i]),
      .side_in  (side_c[i]),
      .v_out    (v_c[i+1]),
      .x_out    (x_c[i+1]),
      .y_out    (y_c[i+1]),
      .z_out    (z_c[i+1]),
      .side_out (side_c[i+1])
    );
  end

  always_comb begin
    xe     = x_c[CORDIC_STEPS];
    ye     = y_c[CORDIC_STEPS];
    side_e = side_c[CORDIC_STEPS];
    quad_e = quad_t'(side_e[SIDE_W-1 -: 2]);
    case (quad_e)
      QUAD_0: begin
        cs_next = xe;
        sn_next = ye;
      end
      QUAD_1: begin
        cs_next = -ye;
        sn_next = xe;
      end
      QUAD_2: begin
        cs_next = -xe;
        sn_next = -ye;
      end
      QUAD_3: begin
        cs_next = ye;
        sn_next = -xe;
      end
      default: begin
        cs_next = xe;
        sn_next = ye;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_map <= 1'b0;
    end else if (adv) begin
      v_map <= v_c[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs         <= cs_next;
      sn         <= sn_next;
      sn_neg     <= -sn_next;
      corner_map <= side_e[SIDE_W-3 -: 2];
      last_map   <= side_e[SIDE_W-5];
      dx         <= side_e[2*CW+2*DW-1 -: DW];
      dy         <= side_e[2*CW+DW-1 -: DW];
      cx         <= side_e[2*CW-1 -: CW];
      cy         <= side_e[CW-1:0];
    end
  end

  rpap_mixer #(.COORD_WIDTH(CW)) u_mix_x (
    .clk (clk),
    .en  (adv),
    .u   (dx),
    .v   (dy),
    .cu  (cs),
    .cv  (sn_neg),
    .c   (cx),
    .res (out_x)
  );

  rpap_mixer #(.COORD_WIDTH(CW)) u_mix_y (
    .clk (clk),
    .en  (adv),
    .u   (dx),
    .v   (dy),
    .cu  (sn),
    .cv  (cs),
    .c   (cy),
    .res (out_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MIX_LAT; k++) begin
        v_m[k] <= 1'b0;
      end
    end else if (adv) begin
      v_m[0] <= v_map;
      for (int k = 1; k < MIX_LAT; k++) begin
        v_m[k] <= v_m[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      corner_m[0] <= corner_map;
      last_m[0]   <= last_map;
      for (int k = 1; k < MIX_LAT; k++) begin
        corner_m[k] <= corner_m[k-1];
        last_m[k]   <= last_m[k-1];
      end
    end
  end

  assign out_valid = v_m[MIX_LAT-1];
  assign corner    = corner_m[MIX_LAT-1];
  assign last      = last_m[MIX_LAT-1];

endmodule
